/* rtl/srt_pkg.sv */
// Package for the sorted record table: record type, codes and name shaping.
package srt_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned NAME_CHARS_DEF = 8;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned AGE_W          = 8;
  localparam int unsigned NAME_W         = 64;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [AGE_W-1:0]        age;
    logic [NAME_W-1:0]       name;
  } rec_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STS_INSERTED   = 3'd0,
    STS_REMOVED    = 3'd1,
    STS_NOT_FOUND  = 3'd2,
    STS_FULL       = 3'd3,
    STS_RECORD     = 3'd4,
    STS_EMPTY_DUMP = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    rec_t     rec;
  } cell_ctrl_t;

  // keep bytes up to the first zero byte, at most nchars of them
  function automatic logic [NAME_W-1:0] shape_name(logic [NAME_W-1:0] raw,
                                                   int unsigned nchars);
    logic [NAME_W-1:0] res;
    logic              run;
    res = '0;
    run = 1'b1;
    for (int unsigned i = 0; i < NAME_W / 8; i++) begin
      if (raw[8*i +: 8] == 8'd0 || i >= nchars) run = 1'b0;
      if (run) res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction

endpackage

/* rtl/srt_cell.sv */
// One slot of the sorted record chain: compare against the request key and shift.
module srt_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic               clk,
  input  srt_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]   cnt,
  input  srt_pkg::rec_t      prev_rec,
  input  srt_pkg::rec_t      next_rec,
  input  srt_pkg::rec_t      head_rec,
  input  logic               lt_in,
  input  logic               hit_in,
  output srt_pkg::rec_t      rec,
  output logic               lt_out,
  output logic               hit_out
);
  import srt_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic occ;
  logic is_tail;

  assign occ     = CNT_W'(IDX) < cnt;
  assign is_tail = (CNT_W'(IDX) + CNT_W'(1)) == cnt;
  assign lt_out  = occ && ($signed(rec_r.key) < $signed(ctrl.rec.key));
  assign hit_out = hit_in || (occ && rec_r.key == ctrl.rec.key);
  assign rec     = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (!lt_out) rec_nxt = lt_in ? ctrl.rec : prev_rec;
      end
      OP_REMOVE: begin
        if (hit_out) rec_nxt = next_rec;
      end
      OP_ROTATE: begin
        rec_nxt = is_tail ? head_rec : next_rec;
      end
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

/* rtl/sorted_record_table.sv */
// Top level of the sorted record table: cell chain, command control and result register.
//
//  channel  handshake          payload
//  in_      in_valid/in_stall  in_command in_key in_age in_name_text
//  out_     out_valid/out_stall out_status out_count out_is_empty_now
//                               out_key out_age out_name out_last
//
// Insert and remove: every cell compares and shifts at once and the result
// shows in the cycle after the request is accepted. A dump enters the dump
// state and then returns each record in turn, the chain rotating one slot per
// result while the output does not stall; the input stalls meanwhile.
// Reset clears the record count and control; the slots need no clearing.
// A stalled result holds; a new request waits until the result register frees.
module sorted_record_table #(
  parameter int unsigned CAPACITY   = srt_pkg::CAPACITY_DEF,
  parameter int unsigned NAME_CHARS = srt_pkg::NAME_CHARS_DEF,
  parameter int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_key,
  input  logic [7:0]         in_age,
  input  logic [63:0]        in_name_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_is_empty_now,
  output logic signed [31:0] out_key,
  output logic [7:0]         out_age,
  output logic [63:0]        out_name,
  output logic               out_last
);
  import srt_pkg::*;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   rem_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  status_t            status_r;
  logic [CNT_W-1:0]   count_r;
  logic               empty_r;
  rec_t               orec_r;
  logic               last_r;

  cell_ctrl_t ctrl;
  rec_t       cell_q   [CAPACITY];
  rec_t       prev_rec [CAPACITY];
  rec_t       next_rec [CAPACITY];
  logic       lt       [CAPACITY];
  logic       hit      [CAPACITY];
  logic       lt_in    [CAPACITY];
  logic       hit_in   [CAPACITY];
  logic       out_free;
  logic       in_acc;
  logic       full;
  logic       found;
  cmd_t       cmd;

  assign cmd      = cmd_t'(in_command);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign full     = cnt_r == CNT_W'(CAPACITY);
  assign found    = hit[CAPACITY-1];

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.rec.key  = in_key;
    ctrl.rec.age  = in_age;
    ctrl.rec.name = shape_name(in_name_text, NAME_CHARS);
    if (in_acc && cmd == CMD_INSERT && !full) ctrl.op = OP_INSERT;
    if (in_acc && cmd == CMD_REMOVE) ctrl.op = OP_REMOVE;
    if (state_r == S_DUMP && out_free) ctrl.op = OP_ROTATE;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_free;
    if (in_acc && (cmd == CMD_INSERT || cmd == CMD_REMOVE)) out_valid_nxt = 1'b1;
    if (in_acc && cmd == CMD_DUMP && cnt_r == '0) out_valid_nxt = 1'b1;
    if (state_r == S_DUMP && out_free) out_valid_nxt = 1'b1;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_rec[g] = ctrl.rec;
      assign lt_in[g]    = 1'b1;
      assign hit_in[g]   = 1'b0;
    end else begin : g_body
      assign prev_rec[g] = cell_q[g-1];
      assign lt_in[g]    = lt[g-1];
      assign hit_in[g]   = hit[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_rec[g] = cell_q[g];
    end else begin : g_mid
      assign next_rec[g] = cell_q[g+1];
    end

    srt_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cnt      (cnt_r),
      .prev_rec (prev_rec[g]),
      .next_rec (next_rec[g]),
      .head_rec (cell_q[0]),
      .lt_in    (lt_in[g]),
      .hit_in   (hit_in[g]),
      .rec      (cell_q[g]),
      .lt_out   (lt[g]),
      .hit_out  (hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            orec_r <= '0;
            last_r <= 1'b1;
            unique case (cmd)
              CMD_INSERT: begin
                if (full) begin
                  status_r <= STS_FULL;
                  count_r  <= cnt_r;
                  empty_r  <= cnt_r == '0;
                end else begin
                  status_r <= STS_INSERTED;
                  cnt_r    <= cnt_r + CNT_W'(1);
                  count_r  <= cnt_r + CNT_W'(1);
                  empty_r  <= 1'b0;
                end
              end
              CMD_REMOVE: begin
                if (found) begin
                  status_r <= STS_REMOVED;
                  cnt_r    <= cnt_r - CNT_W'(1);
                  count_r  <= cnt_r - CNT_W'(1);
                  empty_r  <= cnt_r == CNT_W'(1);
                end else begin
                  status_r <= STS_NOT_FOUND;
                  count_r  <= cnt_r;
                  empty_r  <= cnt_r == '0;
                end
              end
              CMD_DUMP: begin
                if (cnt_r == '0) begin
                  status_r    <= STS_EMPTY_DUMP;
                  count_r     <= '0;
                  empty_r     <= 1'b1;
                end else begin
                  state_r <= S_DUMP;
                  rem_r   <= cnt_r;
                end
              end
              default: ;
            endcase
          end
        end
        S_DUMP: begin
          if (out_free) begin
            status_r    <= STS_RECORD;
            count_r     <= cnt_r;
            empty_r     <= 1'b0;
            orec_r      <= cell_q[0];
            last_r      <= rem_r == CNT_W'(1);
            rem_r       <= rem_r - CNT_W'(1);
            if (rem_r == CNT_W'(1)) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_count        = count_r;
  assign out_is_empty_now = empty_r;
  assign out_key          = orec_r.key;
  assign out_age          = orec_r.age;
  assign out_name         = orec_r.name;
  assign out_last         = last_r;

endmodule
